FILE: hw/rtl/ocwsm_pkg.sv
// ============================================================================
// ocwsm_pkg
// Shared types and fixed constants for the omni chassis wheel speed mixer.
// ============================================================================
package ocwsm_pkg;

    // Signed Q1.14 trig value, -16384 .. 16384.
    typedef logic signed [15:0] t_trig;

    // Signed Q3.12 velocity command.
    typedef logic signed [15:0] t_vel;

    // Configuration register indexes.
    localparam logic REG_RPM_GAIN = 1'b0;
    localparam logic REG_ARM_SUM  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [23:0] RPM_GAIN_RESET = 24'd256;
    localparam logic [15:0] ARM_SUM_RESET  = 16'd4096;

    // Quarter turn (pi/2) in unsigned Q30, used to build the sine table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Number of correction terms after the first in the Taylor series.
    localparam int TAYLOR_STEPS = 7;

    // Denominators (2n)(2n+1) of the Taylor series, for n = 1 .. 7.
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_STEPS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    // Largest trig magnitude (1.0 in Q14).
    localparam logic [14:0] TRIG_ONE = 15'd16384;

    // Rounding offset (one half) for the Q.34 product, and saturation limits.
    localparam logic signed [59:0] ROUND_HALF = 60'sd8589934592;
    localparam logic signed [25:0] WHEEL_MAX  = 26'sd32767;
    localparam logic signed [25:0] WHEEL_MIN  = -26'sd32768;

endpackage

FILE: hw/rtl/ocwsm_sincos.sv
// ============================================================================
// ocwsm_sincos
// Quarter-wave table lookup of sine and cosine of a 16-bit binary angle,
// two register stages: address, then table read with sign.
// ============================================================================
module ocwsm_sincos #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic [15:0]        i_angle,
    output ocwsm_pkg::t_trig   o_sin,
    output ocwsm_pkg::t_trig   o_cos
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = 14 + IW;

    typedef logic [14:0] t_rom [SINE_TABLE_DEPTH + 1];

    // Build the quarter-wave table with a truncated Taylor series in Q30,
    // rounded half up to Q14 and clamped to one.
    function automatic t_rom build_rom();
        t_rom               rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (ocwsm_pkg::HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= ocwsm_pkg::TAYLOR_STEPS; n++) begin
                term = ((term * x2) >> 30) / ocwsm_pkg::TAYLOR_DIV[n - 1];
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            r = (64'(sum) + 64'd32768) >> 16;
            if (r > 64'(ocwsm_pkg::TRIG_ONE)) begin
                r = 64'(ocwsm_pkg::TRIG_ONE);
            end
            rom[k] = r[14:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [15:0]   ang      [2];
    logic [PW-1:0] idx_prod [2];
    logic [IW-1:0] idx      [2];
    logic [IW-1:0] n_addr   [2];
    logic [IW-1:0] r_addr   [2];
    logic          r_neg    [2];
    ocwsm_pkg::t_trig n_val [2];
    ocwsm_pkg::t_trig r_val [2];

    // Lane 0 is sine, lane 1 is cosine (angle advanced by a quarter turn).
    assign ang[0] = i_angle;
    assign ang[1] = i_angle + 16'h4000;

    // Table address from the angle within its quadrant; odd quadrants read
    // the table mirrored.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            idx_prod[i] = PW'(ang[i][13:0]) * PW'(SINE_TABLE_DEPTH);
            idx[i]      = idx_prod[i][PW-1:14];
            if (ang[i][14]) begin
                n_addr[i] = IW'(SINE_TABLE_DEPTH) - idx[i];
            end else begin
                n_addr[i] = idx[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r_addr[i] <= n_addr[i];
            r_neg[i]  <= ang[i][15];
        end
    end

    // Table read; the lower half of the turn is negated.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (r_neg[i]) begin
                n_val[i] = -$signed({1'b0, SINE_ROM[r_addr[i]]});
            end else begin
                n_val[i] = $signed({1'b0, SINE_ROM[r_addr[i]]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r_val[i] <= n_val[i];
        end
    end

    assign o_sin = r_val[0];
    assign o_cos = r_val[1];

endmodule

FILE: hw/rtl/omni_chassis_wheel_speed_mixer.sv
// ============================================================================
// omni_chassis_wheel_speed_mixer
// Four-wheel omni chassis inverse kinematics: rotates the velocity command
// by the frame angle, mixes four wheel speeds, scales them to rpm, rounds
// and saturates them to signed 16 bits.
// ============================================================================
//
//  Channel   Ports                                      Transfer
//  --------  -----------------------------------------  ---------------------
//  command   start, busy, i_vel_x/y/turn, i_frame_angle  start high, busy low
//  result    o_done, o_wheel_one..four, o_clipped        o_done high, 1 cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata            i_cfg_we high
//
//  A command can be taken in every cycle; busy is always low.
//  Each result passes through two stages of sine table lookup, then the
//  products, wheel sums, gain partial products, their combination, and
//  rounding and saturation into the output register.
//  Reset (synchronous, active low) empties the pipeline and restores the
//  gain and arm registers. The receiver cannot stall, so nothing waits.
//
module omni_chassis_wheel_speed_mixer #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel.
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_vel_x,
    input  logic signed [15:0] i_vel_y,
    input  logic signed [15:0] i_vel_turn,
    input  logic [15:0]        i_frame_angle,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [23:0]        i_cfg_wdata,
    // Result channel.
    output logic               o_done,
    output logic signed [15:0] o_wheel_one,
    output logic signed [15:0] o_wheel_two,
    output logic signed [15:0] o_wheel_three,
    output logic signed [15:0] o_wheel_four,
    output logic               o_clipped
);

    localparam int LATENCY = 7;

    // Configuration registers.
    logic [23:0] r_rpm_gain;
    logic [15:0] r_arm_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_gain <= ocwsm_pkg::RPM_GAIN_RESET;
            r_arm_sum  <= ocwsm_pkg::ARM_SUM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ocwsm_pkg::REG_RPM_GAIN: r_rpm_gain <= i_cfg_wdata;
                ocwsm_pkg::REG_ARM_SUM:  r_arm_sum  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // The pipeline takes a command in every cycle.
    assign busy = 1'b0;

    // Valid bits travel alongside the data.
    logic [LATENCY-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[LATENCY-2:0], start & ~busy};
        end
    end

    // Stages 1 and 2: sine and cosine lookup.
    ocwsm_pkg::t_trig sin_v;
    ocwsm_pkg::t_trig cos_v;

    ocwsm_sincos #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sincos (
        .i_clk  (i_clk),
        .i_angle(i_frame_angle),
        .o_sin  (sin_v),
        .o_cos  (cos_v)
    );

    // Velocities follow the lookup through two stages.
    ocwsm_pkg::t_vel r_s1_vx, r_s1_vy, r_s1_vw;
    ocwsm_pkg::t_vel r_s2_vx, r_s2_vy, r_s2_vw;

    always_ff @(posedge i_clk) begin
        r_s1_vx <= i_vel_x;
        r_s1_vy <= i_vel_y;
        r_s1_vw <= i_vel_turn;
        r_s2_vx <= r_s1_vx;
        r_s2_vy <= r_s1_vy;
        r_s2_vw <= r_s1_vw;
    end

    // Stage 3: rotation products and the turn term.
    logic signed [16:0] arm_s;
    logic signed [31:0] r_vxc, r_vys, r_vxs, r_vyc;
    logic signed [32:0] r_vwa;

    assign arm_s = $signed({1'b0, r_arm_sum});

    always_ff @(posedge i_clk) begin
        r_vxc <= r_s2_vx * cos_v;
        r_vys <= r_s2_vy * sin_v;
        r_vxs <= r_s2_vx * sin_v;
        r_vyc <= r_s2_vy * cos_v;
        r_vwa <= r_s2_vw * arm_s;
    end

    // Stage 4: rotated translation and the four wheel sums in Q.26.
    logic signed [32:0] px, py;
    logic signed [34:0] pxe, pye, w;
    logic signed [34:0] n_sum [4];
    logic signed [34:0] r_sum [4];

    always_comb begin
        px       = 33'(r_vxc) + 33'(r_vys);
        py       = 33'(r_vxs) - 33'(r_vyc);
        pxe      = 35'(px);
        pye      = 35'(py);
        w        = 35'(r_vwa) <<< 2;
        n_sum[0] =  pxe - pye + w;
        n_sum[1] =  pxe + pye + w;
        n_sum[2] = -pxe + pye + w;
        n_sum[3] = -pxe - pye + w;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_sum[i] <= n_sum[i];
        end
    end

    // Stage 5: gain split into two 12-bit halves, one product for each.
    logic signed [12:0] gain_lo, gain_hi;
    logic signed [47:0] r_plo [4];
    logic signed [47:0] r_phi [4];

    assign gain_lo = $signed({1'b0, r_rpm_gain[11:0]});
    assign gain_hi = $signed({1'b0, r_rpm_gain[23:12]});

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_plo[i] <= r_sum[i] * gain_lo;
            r_phi[i] <= r_sum[i] * gain_hi;
        end
    end

    // Stage 6: full Q.34 product.
    logic signed [59:0] r_prod [4];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_prod[i] <= (60'(r_phi[i]) <<< 12) + 60'(r_plo[i]);
        end
    end

    // Stage 7: round to nearest with ties away from zero, then saturate.
    // Adding one half, less one for negative values, and flooring gives
    // the away-from-zero rounding in a single add.
    logic signed [59:0] rnd  [4];
    logic signed [25:0] q    [4];
    logic signed [15:0] n_wheel [4];
    logic [3:0]         sat;
    logic signed [15:0] r_wheel [4];
    logic               r_clipped;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rnd[i] = r_prod[i] + ocwsm_pkg::ROUND_HALF - $signed({59'd0, r_prod[i][59]});
            q[i]   = 26'(rnd[i] >>> 34);
            if (q[i] > ocwsm_pkg::WHEEL_MAX) begin
                n_wheel[i] = 16'sh7FFF;
                sat[i]     = 1'b1;
            end else if (q[i] < ocwsm_pkg::WHEEL_MIN) begin
                n_wheel[i] = 16'sh8000;
                sat[i]     = 1'b1;
            end else begin
                n_wheel[i] = q[i][15:0];
                sat[i]     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_wheel[i] <= n_wheel[i];
        end
        r_clipped <= |sat;
    end

    // Result ports.
    assign o_done        = r_valid[LATENCY-1];
    assign o_wheel_one   = r_wheel[0];
    assign o_wheel_two   = r_wheel[1];
    assign o_wheel_three = r_wheel[2];
    assign o_wheel_four  = r_wheel[3];
    assign o_clipped     = r_clipped;

endmodule
